// ----- rtl/bclm_pkg.sv -----
// Package for the battery charge level manager.
// Holds the field widths, register indexes, voltage thresholds and shared types.
// No dependencies; every other file in rtl/ uses it by scoped names.
package bclm_pkg;

   localparam int NUM_LEVELS = 20;
   localparam int LEVEL_W    = 5;
   localparam int ADC_W      = 12;
   localparam int MV_W       = 16;
   localparam int GAIN_W     = 16;
   localparam int OFFSET_W   = 8;
   localparam int CNT_W      = 16;
   localparam int GAIN_FRAC  = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int TABLE_LEN  = 20;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_GAIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_ACTIVE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_IDLE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CHARGE_TIME = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_TIME       = 3'd4;

   localparam logic [GAIN_W-1:0]   VOLT_GAIN_RST       = 16'd4096;
   localparam logic [OFFSET_W-1:0] OFFSET_ACTIVE_RST   = 8'd80;
   localparam logic [OFFSET_W-1:0] OFFSET_IDLE_RST     = 8'd130;
   localparam logic [CNT_W-1:0]    MAX_CHARGE_TIME_RST = 16'd900;
   localparam logic [CNT_W-1:0]    FULL_TIME_RST       = 16'd300;

   // Charge rule thresholds in millivolts.
   localparam logic [MV_W-1:0] MV_OVER_FULL  = 16'd4150;
   localparam logic [MV_W-1:0] MV_FAST_FILL  = 16'd4100;
   localparam logic [MV_W-1:0] MV_TOPPING    = 16'd4000;
   localparam logic [MV_W-1:0] MV_RESTART    = 16'd4020;
   localparam logic [MV_W-1:0] MV_DISCHARGED = 16'd3950;

   localparam logic [CNT_W-1:0] STEP_FAST = 16'd10;
   localparam logic [CNT_W-1:0] STEP_SLOW = 16'd1;

   localparam logic [MV_W-1:0] THRESH [TABLE_LEN] = '{
      16'd3350, 16'd3400, 16'd3500, 16'd3550, 16'd3600,
      16'd3650, 16'd3700, 16'd3720, 16'd3750, 16'd3800,
      16'd3820, 16'd3850, 16'd3880, 16'd3900, 16'd3930,
      16'd3950, 16'd3980, 16'd4000, 16'd4020, 16'd4080
   };

   typedef struct packed {
      logic [GAIN_W-1:0]   volt_gain;
      logic [OFFSET_W-1:0] offset_active;
      logic [OFFSET_W-1:0] offset_idle;
      logic [CNT_W-1:0]    max_charge_time;
      logic [CNT_W-1:0]    full_time;
   } cfg_type;

   typedef struct packed {
      logic             req_type;
      logic             usb_present;
      logic             ic_charging;
      logic [ADC_W-1:0] bat_adc;
   } item_type;

   typedef struct packed {
      logic               tick_phase;
      logic [LEVEL_W-1:0] level;
      logic [MV_W-1:0]    mv;
      logic [CNT_W-1:0]   charge_time;
      logic [CNT_W-1:0]   full_count;
      logic               off_flag;
      logic               enable;
   } state_type;

   function automatic logic [CNT_W-1:0] sat_add16(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

endpackage

// ----- rtl/bclm_req_if.sv -----
// Request channel of the battery charge level manager: valid, ready and one tick.
// Depends on bclm_pkg for the sample width.
interface bclm_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic                      usb_present;
   logic                      ic_charging;
   logic [bclm_pkg::ADC_W-1:0] bat_adc;

   modport source(output valid, output req_type, output usb_present,
                  output ic_charging, output bat_adc, input ready);
   modport sink(input valid, input req_type, input usb_present,
                input ic_charging, input bat_adc, output ready);
endinterface

// ----- rtl/bclm_rsp_if.sv -----
// Result channel of the battery charge level manager: valid, ready and one status.
// Depends on bclm_pkg for the field widths.
interface bclm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bclm_pkg::LEVEL_W-1:0] disp_level;
   logic [bclm_pkg::MV_W-1:0]    battery_mv;
   logic                        charge_enable;
   logic                        charge_stopped;
   logic                        animating;
   logic [bclm_pkg::CNT_W-1:0]   charge_ticks;
   logic [bclm_pkg::CNT_W-1:0]   full_ticks;

   modport source(output valid, output disp_level, output battery_mv,
                  output charge_enable, output charge_stopped, output animating,
                  output charge_ticks, output full_ticks, input ready);
   modport sink(input valid, input disp_level, input battery_mv,
                input charge_enable, input charge_stopped, input animating,
                input charge_ticks, input full_ticks, output ready);
endinterface

// ----- rtl/bclm_step.sv -----
// Next-state logic of the battery charge level manager for one tick.
// Depends on bclm_pkg for types, thresholds and the saturating add.
module bclm_step #(
   parameter int NUM_LEVELS = bclm_pkg::NUM_LEVELS
) (
   input  bclm_pkg::item_type  item,
   input  bclm_pkg::state_type cur,
   input  bclm_pkg::cfg_type   cfg,
   output bclm_pkg::state_type state_in,
   output logic                anim
);

   localparam int LW = bclm_pkg::LEVEL_W;
   localparam int CW = bclm_pkg::CNT_W;
   localparam logic [LW:0]   NumLv    = (LW+1)'(NUM_LEVELS);
   localparam logic [LW-1:0] TopLv    = LW'(NUM_LEVELS - 1);
   localparam logic [LW-1:0] LevelMax = {LW{1'b1}};

   localparam int ProdW = bclm_pkg::ADC_W + bclm_pkg::GAIN_W;

   logic [ProdW-1:0]                prod;
   logic [bclm_pkg::MV_W-1:0]       base_mv;
   logic [bclm_pkg::OFFSET_W-1:0]   offset;
   logic [bclm_pkg::MV_W-1:0]       mv;
   logic [LW-1:0]                   lvl;
   logic [CW-1:0]                   ct_fast;
   logic [CW-1:0]                   ct_slow;
   logic [CW-1:0]                   fc_next;
   logic [CW-1:0]                   ct_new;

   assign prod    = ProdW'(item.bat_adc) * ProdW'(cfg.volt_gain);
   assign base_mv = prod[ProdW-1:bclm_pkg::GAIN_FRAC];
   assign offset  = (item.ic_charging && !cur.off_flag) ? cfg.offset_active
                                                        : cfg.offset_idle;
   assign mv      = bclm_pkg::sat_add16(base_mv, CW'(offset));

   // Thresholds rise monotonically, so the last one reached gives the level.
   always_comb begin
      lvl = '0;
      for (int i = 0; i < bclm_pkg::TABLE_LEN; i++) begin
         if (i < NUM_LEVELS && mv >= bclm_pkg::THRESH[i]) begin
            lvl = LW'(i + 1);
         end
      end
   end

   assign ct_fast = bclm_pkg::sat_add16(cur.charge_time, bclm_pkg::STEP_FAST);
   assign ct_slow = bclm_pkg::sat_add16(cur.charge_time, bclm_pkg::STEP_SLOW);
   assign fc_next = bclm_pkg::sat_add16(cur.full_count,
                       (mv >= bclm_pkg::MV_FAST_FILL) ? bclm_pkg::STEP_FAST
                                                      : bclm_pkg::STEP_SLOW);

   always_comb begin
      state_in = cur;
      anim     = 1'b0;
      ct_new   = cur.charge_time;
      if (item.req_type) begin
         state_in.mv    = mv;
         state_in.level = lvl;
      end else if (!cur.tick_phase) begin
         state_in.tick_phase = 1'b1;
      end else begin
         state_in.tick_phase = 1'b0;
         if (item.usb_present) begin
            anim = 1'b1;
            if ({1'b0, cur.level} < NumLv && cur.level != LevelMax) begin
               state_in.level = cur.level + LW'(1);
            end else begin
               // At the top of the display: re-measure and apply the charge rules.
               state_in.mv    = mv;
               state_in.level = lvl;
               if ({1'b0, lvl} >= NumLv) begin
                  if (mv > bclm_pkg::MV_OVER_FULL) begin
                     if (cur.charge_time < cfg.max_charge_time) begin
                        state_in.charge_time = ct_fast;
                        if (ct_fast >= cfg.max_charge_time) begin
                           state_in.enable   = 1'b0;
                           state_in.off_flag = 1'b1;
                        end
                     end
                     state_in.full_count = cfg.full_time;
                  end else if (cur.full_count < cfg.full_time) begin
                     state_in.full_count = fc_next;
                     state_in.level      = TopLv;
                     state_in.enable     = 1'b1;
                  end
               end else if (mv > bclm_pkg::MV_TOPPING) begin
                  if (cur.charge_time < cfg.max_charge_time) begin
                     ct_new = ct_slow;
                     if (ct_slow == cfg.max_charge_time) begin
                        state_in.enable   = 1'b0;
                        state_in.off_flag = 1'b1;
                     end
                  end
                  state_in.charge_time = ct_new;
                  if (mv < bclm_pkg::MV_RESTART &&
                      (cur.full_count >= cfg.full_time ||
                       ct_new >= cfg.max_charge_time)) begin
                     state_in.enable      = 1'b1;
                     state_in.full_count  = '0;
                     state_in.charge_time = '0;
                     state_in.off_flag    = 1'b0;
                  end
               end else if (mv < bclm_pkg::MV_DISCHARGED) begin
                  state_in.charge_time = '0;
                  state_in.full_count  = '0;
               end
            end
         end
      end
   end

endmodule

// ----- rtl/battery_charge_level_manager.sv -----
// Top level of the battery charge level manager.
// Depends on bclm_pkg, bclm_req_if, bclm_rsp_if and bclm_step.
//
// The block takes one request per clock cycle while the result side takes every
// status and returns exactly one status per request, in order. A transferred request
// is held in an input register, processed in a single pass through the measurement,
// level lookup and charge-rule logic, and its status is registered in the result
// register once the result side is free to take it. That single pass (a 12 by 16
// bit multiply, a saturating add, the threshold compares and the rule muxing) also
// carries the state feedback from one request to the next. When the result side
// stalls, the input register still takes one more request. Configuration writes
// are taken at any edge with csr_we high and should only be issued while the block
// is idle.
module battery_charge_level_manager #(
   parameter int NUM_LEVELS = bclm_pkg::NUM_LEVELS
) (
   input  logic                              clock,
   input  logic                              reset,
   bclm_req_if.sink                          req_chan,
   bclm_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [bclm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bclm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bclm_pkg::cfg_type   cfg_ff;
   bclm_pkg::item_type  item_ff;
   bclm_pkg::state_type state_ff;
   bclm_pkg::state_type state_in;
   logic                in_valid_ff;
   logic                out_valid_ff;
   logic                anim_in;
   logic                anim_ff;
   logic                advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_gain       <= bclm_pkg::VOLT_GAIN_RST;
         cfg_ff.offset_active   <= bclm_pkg::OFFSET_ACTIVE_RST;
         cfg_ff.offset_idle     <= bclm_pkg::OFFSET_IDLE_RST;
         cfg_ff.max_charge_time <= bclm_pkg::MAX_CHARGE_TIME_RST;
         cfg_ff.full_time       <= bclm_pkg::FULL_TIME_RST;
      end else if (csr_we) begin
         case (csr_index)
            bclm_pkg::CSR_VOLT_GAIN: begin
               cfg_ff.volt_gain <= csr_wdata[bclm_pkg::GAIN_W-1:0];
            end
            bclm_pkg::CSR_OFFSET_ACTIVE: begin
               cfg_ff.offset_active <= csr_wdata[bclm_pkg::OFFSET_W-1:0];
            end
            bclm_pkg::CSR_OFFSET_IDLE: begin
               cfg_ff.offset_idle <= csr_wdata[bclm_pkg::OFFSET_W-1:0];
            end
            bclm_pkg::CSR_MAX_CHARGE_TIME: begin
               cfg_ff.max_charge_time <= csr_wdata[bclm_pkg::CNT_W-1:0];
            end
            bclm_pkg::CSR_FULL_TIME: begin
               cfg_ff.full_time <= csr_wdata[bclm_pkg::CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         item_ff.req_type    <= req_chan.req_type;
         item_ff.usb_present <= req_chan.usb_present;
         item_ff.ic_charging <= req_chan.ic_charging;
         item_ff.bat_adc     <= req_chan.bat_adc;
      end
   end

   bclm_step #(
      .NUM_LEVELS(NUM_LEVELS)
   ) u_step (
      .item     (item_ff),
      .cur      (state_ff),
      .cfg      (cfg_ff),
      .state_in (state_in),
      .anim     (anim_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         anim_ff <= anim_in;
      end
   end

   // The state registers always equal the fields of the last status produced.
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.disp_level     = state_ff.level;
   assign rsp_chan.battery_mv     = state_ff.mv;
   assign rsp_chan.charge_enable  = state_ff.enable;
   assign rsp_chan.charge_stopped = state_ff.off_flag;
   assign rsp_chan.animating      = anim_ff;
   assign rsp_chan.charge_ticks   = state_ff.charge_time;
   assign rsp_chan.full_ticks     = state_ff.full_count;

   // The displayed level never passes the number of levels.
   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.level} <= (bclm_pkg::LEVEL_W+1)'(NUM_LEVELS))
      else $error("battery level beyond the top of the display");

   // A held request must not disturb the charge state.
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("charge state changed without a processed request");

   // An animating status comes from the acting half of the tick pair.
   a_anim_phase : assert property (@(posedge clock) disable iff (reset)
      (advance && anim_in) |=> (!state_ff.tick_phase && anim_ff))
      else $error("animating status without the tick phase clearing");

   // Every transferred request is held until it is processed.
   a_req_held : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> in_valid_ff)
      else $error("transferred request was lost");

endmodule
